// ----- hw/rtl/tsvu_pkg.sv -----
// ----------------------------------------------------------------------------
// tsvu_pkg
// Types, codes and helper functions shared by the trampoline slot value unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tsvu_pkg;

	localparam int unsigned InTdataWidth  = 280;
	localparam int unsigned InTuserWidth  = 5;
	localparam int unsigned OutTdataWidth = 200;
	localparam int unsigned OutTuserWidth = 2;

	typedef enum logic [4:0] {
		KIND_HANDLER     = 5'd0,
		KIND_NEXT_PC     = 5'd1,
		KIND_INSTR       = 5'd2,
		KIND_ADR         = 5'd3,
		KIND_IMM19       = 5'd4,
		KIND_IMM26       = 5'd5,
		KIND_PATCH_COND  = 5'd6,
		KIND_PATCH_SF    = 5'd7,
		KIND_PATCH_OP    = 5'd8,
		KIND_PATCH_RN    = 5'd9,
		KIND_PATCH_RT    = 5'd10,
		KIND_PATCH_RT_RN = 5'd11,
		KIND_PATCH_TBZ   = 5'd12,
		KIND_PATCH_SIZE  = 5'd13,
		KIND_RET_PC4     = 5'd14,
		KIND_RET_IMM26   = 5'd15,
		KIND_RET_IMM19   = 5'd16,
		KIND_RET_IMM14   = 5'd17
	} kind_t;

	typedef enum logic [1:0] {
		SET_A32 = 2'd0,
		SET_T16 = 2'd1,
		SET_T32 = 2'd2,
		SET_A64 = 2'd3
	} insn_set_t;

	localparam logic [1:0] SIZE_16 = 2'd0;
	localparam logic [1:0] SIZE_32 = 2'd1;
	localparam logic [1:0] SIZE_64 = 2'd2;

	localparam logic [31:0] MASK_COND = 32'h0000_000f;
	localparam logic [31:0] MASK_SF   = 32'h8000_0000;
	localparam logic [31:0] MASK_OP   = 32'h0100_0000;
	localparam logic [31:0] MASK_RN   = 32'h0000_03e0;
	localparam logic [31:0] MASK_RT   = 32'h0000_001f;
	localparam logic [31:0] MASK_TBZ  = 32'h80f8_0000;
	localparam logic [31:0] MASK_SIZE = 32'h4000_0000;
	localparam logic [63:0] PAGE_MASK = 64'hffff_ffff_ffff_f000;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] instr_word;
		insn_set_t   insn_set;
		logic [63:0] instr_address;
		logic [63:0] handler_target;
		logic [63:0] stub_base;
		logic [15:0] slot_offset;
		logic [31:0] slot_word;
	} req_t;

	typedef struct packed {
		logic        write_valid;
		logic [1:0]  write_size;
		logic [63:0] write_value;
		logic        return_valid;
		logic [63:0] return_site;
		logic [63:0] return_target;
	} res_t;

	function automatic logic [63:0] imm19_ofs(input logic [31:0] w);
		return {{43{w[23]}}, w[23:5], 2'b00};
	endfunction

	function automatic logic [63:0] imm26_ofs(input logic [31:0] w);
		return {{36{w[25]}}, w[25:0], 2'b00};
	endfunction

	function automatic logic [63:0] imm14_ofs(input logic [31:0] w);
		return {{48{w[18]}}, w[18:5], 2'b00};
	endfunction

	function automatic logic [63:0] adr_ofs(input logic [31:0] w);
		logic [63:0] imm;
		imm = {{43{w[23]}}, w[23:5], w[30:29]};
		return w[31] ? {imm[51:0], 12'h000} : imm;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/tsvu_calc.sv -----
// ----------------------------------------------------------------------------
// tsvu_calc
// Slot value logic: one shared target adder, the return place adder and the
// selection of write and return fields for one request.
// ----------------------------------------------------------------------------
`default_nettype none

module tsvu_calc
	import tsvu_pkg::*;
(
	input  var req_t req,
	output var res_t res
);

	logic        a64;
	logic        thumb;
	logic [63:0] add_a;
	logic [63:0] add_b;
	logic [63:0] add_sum;
	logic [63:0] place_sum;
	logic [31:0] mask;
	logic [31:0] src;
	logic [63:0] patched;

	assign a64       = (req.insn_set == SET_A64);
	assign thumb     = (req.insn_set == SET_T16) || (req.insn_set == SET_T32);
	assign add_sum   = add_a + add_b;
	assign place_sum = req.stub_base + {48'd0, req.slot_offset};
	assign patched   = {32'd0, (req.slot_word & ~mask) | (src & mask)};

	always_comb begin
		add_a = req.instr_address;
		add_b = 64'd4;
		mask  = MASK_COND;
		src   = req.instr_word;
		case (req.kind)
			KIND_NEXT_PC: begin
				add_b = (req.insn_set == SET_T16) ? 64'd2 : 64'd4;
			end
			KIND_ADR: begin
				add_a = req.instr_word[31] ? (req.instr_address & PAGE_MASK)
				                           : req.instr_address;
				add_b = adr_ofs(req.instr_word);
			end
			KIND_IMM19, KIND_RET_IMM19: add_b = imm19_ofs(req.instr_word);
			KIND_IMM26, KIND_RET_IMM26: add_b = imm26_ofs(req.instr_word);
			KIND_RET_IMM14:             add_b = imm14_ofs(req.instr_word);
			KIND_PATCH_SF:   mask = MASK_SF;
			KIND_PATCH_OP:   mask = MASK_OP;
			KIND_PATCH_RN:   mask = MASK_RN;
			KIND_PATCH_RT:   mask = MASK_RT;
			KIND_PATCH_RT_RN: begin
				mask = MASK_RN;
				src  = {req.instr_word[26:0], 5'd0};
			end
			KIND_PATCH_TBZ:  mask = MASK_TBZ;
			KIND_PATCH_SIZE: mask = MASK_SIZE;
			default: ;
		endcase
	end

	always_comb begin
		res = '0;
		case (req.kind)
			KIND_HANDLER: begin
				res.write_valid = 1'b1;
				res.write_size  = a64 ? SIZE_64 : SIZE_32;
				res.write_value = a64 ? req.handler_target
				                      : {32'd0, req.handler_target[31:0]};
			end
			KIND_NEXT_PC: begin
				res.write_valid = 1'b1;
				res.write_size  = a64 ? SIZE_64 : SIZE_32;
				res.write_value = a64 ? add_sum
				                      : {32'd0, add_sum[31:1], add_sum[0] | thumb};
			end
			KIND_INSTR: begin
				res.write_valid = 1'b1;
				case (req.insn_set)
					SET_T16: begin
						res.write_size  = SIZE_16;
						res.write_value = {48'd0, req.instr_word[15:0]};
					end
					SET_T32: begin
						res.write_size  = SIZE_32;
						res.write_value = {32'd0, req.instr_word[15:0],
						                   req.instr_word[31:16]};
					end
					default: begin
						res.write_size  = SIZE_32;
						res.write_value = {32'd0, req.instr_word};
					end
				endcase
			end
			KIND_ADR, KIND_IMM19, KIND_IMM26: begin
				res.write_valid = 1'b1;
				res.write_size  = SIZE_64;
				res.write_value = add_sum;
			end
			KIND_PATCH_COND, KIND_PATCH_SF, KIND_PATCH_OP, KIND_PATCH_RN,
			KIND_PATCH_RT, KIND_PATCH_RT_RN, KIND_PATCH_TBZ, KIND_PATCH_SIZE: begin
				if (a64) begin
					res.write_valid = 1'b1;
					res.write_size  = SIZE_32;
					res.write_value = patched;
				end
			end
			KIND_RET_PC4, KIND_RET_IMM26, KIND_RET_IMM19, KIND_RET_IMM14: begin
				if (a64) begin
					res.return_valid  = 1'b1;
					res.return_site   = place_sum;
					res.return_target = add_sum;
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// ----- hw/rtl/trampoline_slot_value_unit_core.sv -----
// ----------------------------------------------------------------------------
// trampoline_slot_value_unit_core
// Computes the word to store into one trampoline stub slot per request.
// ----------------------------------------------------------------------------
// Each request is registered on input, passes through one stage of slot value
// logic and lands in a result register, from which it is offered on the output;
// one request per cycle is sustained while the result side does not stall. The
// unit holds no state between requests; a stall on the result side holds both
// stages.
`default_nettype none

module trampoline_slot_value_unit_core
	import tsvu_pkg::*;
(
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       s_tvalid,
	output logic                      s_tready,
	// instr_word, insn_set, instr_address, handler_target, stub_base,
	// slot_offset, slot_word, zero fill
	input  wire  [InTdataWidth-1:0]   s_tdata,
	// kind
	input  wire  [InTuserWidth-1:0]   s_tuser,
	output logic                      m_tvalid,
	input  wire                       m_tready,
	// write_size, write_value, return_site, return_target, zero fill
	output logic [OutTdataWidth-1:0]  m_tdata,
	// write_valid, return_valid
	output logic [OutTuserWidth-1:0]  m_tuser
);

	logic valid_s1;
	logic valid_s2;
	logic adv_s2;
	req_t req_s1;
	res_t res_c;
	res_t res_s2;

	assign adv_s2   = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) valid_s1 <= s_tvalid;
			if (adv_s2)   valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			req_s1.kind           <= kind_t'(s_tuser[4:0]);
			req_s1.instr_word     <= s_tdata[31:0];
			req_s1.insn_set       <= insn_set_t'(s_tdata[33:32]);
			req_s1.instr_address  <= s_tdata[97:34];
			req_s1.handler_target <= s_tdata[161:98];
			req_s1.stub_base      <= s_tdata[225:162];
			req_s1.slot_offset    <= s_tdata[241:226];
			req_s1.slot_word      <= s_tdata[273:242];
		end
		if (adv_s2 && valid_s1) res_s2 <= res_c;
	end

	tsvu_calc u_calc (
		.req (req_s1),
		.res (res_c)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {6'd0, res_s2.return_target, res_s2.return_site,
	                   res_s2.write_value, res_s2.write_size};
	assign m_tuser  = {res_s2.return_valid, res_s2.write_valid};

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for trampoline_slot_value_unit_core. A driver and a
// monitor, both clocked, move slot requests and results over the two stream
// ports. Each accepted request is run through a local model of the slot value
// rules and the result is queued. Each result that leaves the unit is checked
// field by field against the oldest queued result. The stimulus starts with
// directed requests: extreme addresses, every kind, the Thumb cases, ADR and
// ADRP, the patch and return kinds on non-A64 sets, and an unknown kind. Random
// requests follow, with idle bursts on both sides, one long result-side
// hold-off and sender pauses until the unit has drained.
// ----------------------------------------------------------------------------
module tb;
	import tsvu_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RandomItems   = 725;
	localparam int unsigned QuietTail     = 100;
	localparam int unsigned HoldAt        = 300;
	localparam int unsigned HoldCycles    = 200;
	localparam int unsigned DrainAt       = 350;
	localparam int unsigned TailCycles    = 8;
	localparam int unsigned WatchdogLimit = 2000;

	typedef struct {
		req_t req;
		bit   wait_idle;
	} slot_job_t;

	logic                     clk;
	logic                     arst_n;
	logic                     s_tvalid = 1'b0;
	logic                     s_tready;
	logic [InTdataWidth-1:0]  s_tdata = '0;
	logic [InTuserWidth-1:0]  s_tuser = '0;
	logic                     m_tvalid;
	logic                     m_tready = 1'b0;
	logic [OutTdataWidth-1:0] m_tdata;
	logic [OutTuserWidth-1:0] m_tuser;

	slot_job_t   request_q[$];
	res_t        pending_results[$];
	req_t        cur_req = '0;
	logic        in_fire = 1'b0;
	int unsigned n_in = 0;
	int unsigned n_out = 0;
	int unsigned fail_count = 0;
	int unsigned quiet_from = 32'hffff_ffff;
	int unsigned send_gap = 0;
	int unsigned stall_left = 0;
	int unsigned hold_left = 0;
	bit          hold_done = 1'b0;
	int unsigned idle_cycles = 0;

	trampoline_slot_value_unit_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	function automatic logic [63:0] imm19_dest(logic [63:0] pc, logic [31:0] w);
		logic signed [20:0] d;
		d = {w[23:5], 2'b00};
		return pc + 64'(d);
	endfunction

	function automatic logic [63:0] imm26_dest(logic [63:0] pc, logic [31:0] w);
		logic signed [27:0] d;
		d = {w[25:0], 2'b00};
		return pc + 64'(d);
	endfunction

	function automatic res_t slot_value_of(req_t r);
		res_t               o;
		logic [63:0]        pc;
		logic [63:0]        nxt;
		logic [63:0]        imm;
		logic [31:0]        w;
		logic [31:0]        mask;
		logic [31:0]        src;
		logic signed [20:0] a21;
		logic signed [15:0] d14;
		logic               a64;
		logic               thumb;
		o     = '0;
		w     = r.instr_word;
		pc    = r.instr_address;
		a64   = (r.insn_set == SET_A64);
		thumb = (r.insn_set == SET_T16) || (r.insn_set == SET_T32);
		mask  = '0;
		src   = w;
		case (r.kind)
			KIND_HANDLER: begin
				o.write_valid = 1'b1;
				o.write_size  = a64 ? SIZE_64 : SIZE_32;
				o.write_value = a64 ? r.handler_target : {32'b0, r.handler_target[31:0]};
			end
			KIND_NEXT_PC: begin
				nxt = pc + ((r.insn_set == SET_T16) ? 64'd2 : 64'd4);
				if (thumb)
					nxt[0] = 1'b1;
				o.write_valid = 1'b1;
				o.write_size  = a64 ? SIZE_64 : SIZE_32;
				o.write_value = a64 ? nxt : {32'b0, nxt[31:0]};
			end
			KIND_INSTR: begin
				o.write_valid = 1'b1;
				if (r.insn_set == SET_T16) begin
					o.write_size  = SIZE_16;
					o.write_value = {48'b0, w[15:0]};
				end else if (r.insn_set == SET_T32) begin
					o.write_size  = SIZE_32;
					o.write_value = {32'b0, w[15:0], w[31:16]};
				end else begin
					o.write_size  = SIZE_32;
					o.write_value = {32'b0, w};
				end
			end
			KIND_ADR: begin
				a21 = {w[23:5], w[30:29]};
				imm = 64'(a21);
				if (w[31]) begin
					imm = imm << 12;
					pc  = pc & PAGE_MASK;
				end
				o.write_valid = 1'b1;
				o.write_size  = SIZE_64;
				o.write_value = pc + imm;
			end
			KIND_IMM19: begin
				o.write_valid = 1'b1;
				o.write_size  = SIZE_64;
				o.write_value = imm19_dest(pc, w);
			end
			KIND_IMM26: begin
				o.write_valid = 1'b1;
				o.write_size  = SIZE_64;
				o.write_value = imm26_dest(pc, w);
			end
			KIND_PATCH_COND, KIND_PATCH_SF, KIND_PATCH_OP, KIND_PATCH_RN,
			KIND_PATCH_RT, KIND_PATCH_RT_RN, KIND_PATCH_TBZ, KIND_PATCH_SIZE: begin
				if (a64) begin
					case (r.kind)
						KIND_PATCH_COND: mask = MASK_COND;
						KIND_PATCH_SF:   mask = MASK_SF;
						KIND_PATCH_OP:   mask = MASK_OP;
						KIND_PATCH_RN:   mask = MASK_RN;
						KIND_PATCH_RT:   mask = MASK_RT;
						KIND_PATCH_RT_RN: begin
							mask = MASK_RN;
							src  = w << 5;
						end
						KIND_PATCH_TBZ:  mask = MASK_TBZ;
						default:         mask = MASK_SIZE;
					endcase
					o.write_valid = 1'b1;
					o.write_size  = SIZE_32;
					o.write_value = {32'b0, (r.slot_word & ~mask) | (src & mask)};
				end
			end
			KIND_RET_PC4, KIND_RET_IMM26, KIND_RET_IMM19, KIND_RET_IMM14: begin
				if (a64) begin
					o.return_valid = 1'b1;
					o.return_site  = r.stub_base + {48'b0, r.slot_offset};
					case (r.kind)
						KIND_RET_PC4:   o.return_target = pc + 64'd4;
						KIND_RET_IMM26: o.return_target = imm26_dest(pc, w);
						KIND_RET_IMM19: o.return_target = imm19_dest(pc, w);
						default: begin
							d14 = {w[18:5], 2'b00};
							o.return_target = pc + 64'(d14);
						end
					endcase
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	task automatic add_req(kind_t k, insn_set_t s, logic [31:0] w, logic [63:0] pc,
			logic [63:0] handler, logic [63:0] base, logic [15:0] off,
			logic [31:0] slot, bit wait_idle);
		slot_job_t j;
		j.req.kind           = k;
		j.req.instr_word     = w;
		j.req.insn_set       = s;
		j.req.instr_address  = pc;
		j.req.handler_target = handler;
		j.req.stub_base      = base;
		j.req.slot_offset    = off;
		j.req.slot_word      = slot;
		j.wait_idle          = wait_idle;
		request_q.push_back(j);
	endtask

	function automatic logic [63:0] random_addr();
		logic [63:0] a;
		a = {$urandom, $urandom};
		case ($urandom_range(0, 7))
			0: a = 64'hffff_ffff_ffff_ffff - 64'($urandom_range(0, 4095));
			1: a = 64'($urandom_range(0, 4095));
			default: ;
		endcase
		return a;
	endfunction

	function automatic logic [15:0] random_offset();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hffff;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic add_random_req(bit wait_idle);
		kind_t     k;
		insn_set_t s;
		if ($urandom_range(0, 24) == 0)
			k = kind_t'(5'($urandom_range(18, 31)));
		else
			k = kind_t'(5'($urandom_range(0, 17)));
		if ($urandom_range(0, 1) == 0)
			s = SET_A64;
		else
			s = insn_set_t'(2'($urandom_range(0, 3)));
		add_req(k, s, $urandom, random_addr(), random_addr(), random_addr(),
			random_offset(), $urandom, wait_idle);
	endtask

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %h, got %h", name, want, got);
			fail_count++;
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		res_t want;
		res_t got;
		if (!arst_n) begin
			in_fire <= 1'b0;
		end else begin
			in_fire <= s_tvalid && s_tready;
			if (s_tvalid && s_tready) begin
				pending_results.push_back(slot_value_of(cur_req));
				n_in++;
			end
			if (m_tvalid && m_tready) begin
				n_out++;
				got.write_valid   = m_tuser[0];
				got.return_valid  = m_tuser[1];
				got.write_size    = m_tdata[1:0];
				got.write_value   = m_tdata[65:2];
				got.return_site   = m_tdata[129:66];
				got.return_target = m_tdata[193:130];
				if (pending_results.size() == 0) begin
					$error("result transfer with no request outstanding");
					fail_count++;
				end else begin
					want = pending_results.pop_front();
					check_field("write_valid", 64'(want.write_valid), 64'(got.write_valid));
					check_field("write_size", 64'(want.write_size), 64'(got.write_size));
					check_field("write_value", want.write_value, got.write_value);
					check_field("return_valid", 64'(want.return_valid), 64'(got.return_valid));
					check_field("return_site", want.return_site, got.return_site);
					check_field("return_target", want.return_target, got.return_target);
				end
			end
		end
	end

	always @(negedge clk) begin
		slot_job_t job;
		if (arst_n && (!s_tvalid || in_fire)) begin
			if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (request_q.size() > 0 &&
					!(request_q[0].wait_idle && pending_results.size() > 0)) begin
				job = request_q.pop_front();
				cur_req  <= job.req;
				s_tdata  <= {6'b0, job.req.slot_word, job.req.slot_offset, job.req.stub_base,
					job.req.handler_target, job.req.instr_address, job.req.insn_set,
					job.req.instr_word};
				s_tuser  <= job.req.kind;
				s_tvalid <= 1'b1;
				if (n_in < quiet_from && $urandom_range(0, 7) == 0)
					send_gap = $urandom_range(1, 12);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		logic rdy;
		if (arst_n) begin
			rdy = 1'b1;
			if (!hold_done && n_in >= HoldAt) begin
				hold_left = HoldCycles;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else if (n_in < quiet_from) begin
				if (stall_left > 0) begin
					stall_left--;
					rdy = 1'b0;
				end else if ($urandom_range(0, 15) == 0) begin
					stall_left = $urandom_range(1, 12) - 1;
					rdy = 1'b0;
				end
			end
			m_tready <= rdy;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WatchdogLimit) begin
				$display("tb: no transfer for %0d cycles", idle_cycles);
				$display("tb: done, errors");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;

		add_req(KIND_HANDLER, SET_A64, 32'h0, 64'h0, 64'hffff_ffff_ffff_ffff, 64'h0,
			16'h0, 32'h0, 1'b0);
		add_req(KIND_HANDLER, SET_A32, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff,
			64'h8765_4321_dead_beef, 64'h0, 16'hffff, 32'hffff_ffff, 1'b0);
		add_req(KIND_NEXT_PC, SET_A64, 32'h0, 64'hffff_ffff_ffff_fffe, 64'h0, 64'h0,
			16'h0, 32'h0, 1'b0);
		add_req(KIND_NEXT_PC, SET_T16, 32'h0, 64'hffff_ffff_ffff_fffe, 64'h0, 64'h0,
			16'h0, 32'h0, 1'b0);
		add_req(KIND_NEXT_PC, SET_T32, 32'h0, 64'h0, 64'h0, 64'h0, 16'h0, 32'h0, 1'b0);
		add_req(KIND_NEXT_PC, SET_A32, 32'h0, 64'h1234_5678_ffff_fffc, 64'h0, 64'h0,
			16'h0, 32'h0, 1'b0);
		add_req(KIND_INSTR, SET_T16, 32'habcd_1234, 64'h0, 64'h0, 64'h0, 16'h0,
			32'h0, 1'b0);
		add_req(KIND_INSTR, SET_T32, 32'hf000_b800, 64'h0, 64'h0, 64'h0, 16'h0,
			32'h0, 1'b0);
		add_req(KIND_INSTR, SET_A64, 32'hffff_ffff, 64'h0, 64'h0, 64'h0, 16'h0,
			32'h0, 1'b0);
		add_req(KIND_ADR, SET_A64, 32'h7000_0000, 64'h0000_0000_0000_1234, 64'h0, 64'h0,
			16'h0, 32'h0, 1'b0);
		add_req(KIND_ADR, SET_A64, 32'hf0ff_ffe0, 64'h0000_0000_0000_0fff, 64'h0, 64'h0,
			16'h0, 32'h0, 1'b0);
		add_req(KIND_ADR, SET_T32, 32'h9080_0000, 64'hffff_ffff_ffff_ffff, 64'h0, 64'h0,
			16'h0, 32'h0, 1'b0);
		add_req(KIND_IMM19, SET_A64, 32'h0080_0000, 64'h0, 64'h0, 64'h0, 16'h0,
			32'h0, 1'b0);
		add_req(KIND_IMM26, SET_A32, 32'h03ff_ffff, 64'h0, 64'h0, 64'h0, 16'h0,
			32'h0, 1'b0);
		add_req(KIND_IMM26, SET_A64, 32'h01ff_ffff, 64'hffff_ffff_ffff_ffff, 64'h0,
			64'h0, 16'h0, 32'h0, 1'b0);
		for (int k = KIND_PATCH_COND; k <= KIND_PATCH_SIZE; k++)
			add_req(kind_t'(5'(k)), SET_A64, (k % 2 == 0) ? 32'hffff_ffff : 32'h0,
				64'h0, 64'h0, 64'h0, 16'h0, (k % 2 == 0) ? 32'h0 : 32'hffff_ffff, 1'b0);
		add_req(KIND_PATCH_RN, SET_T32, 32'hffff_ffff, 64'h0, 64'h0, 64'h0, 16'h0,
			32'h1234_5678, 1'b0);
		add_req(KIND_RET_PC4, SET_A64, 32'h0, 64'hffff_ffff_ffff_fffc,
			64'h0, 64'hffff_ffff_ffff_ffff, 16'hffff, 32'h0, 1'b0);
		add_req(KIND_RET_IMM26, SET_A64, 32'h0200_0000, 64'h0, 64'h0, 64'h0, 16'h0,
			32'h0, 1'b0);
		add_req(KIND_RET_IMM19, SET_A64, 32'h007f_ffe0, 64'h0, 64'h0, 64'h1000,
			16'h0010, 32'h0, 1'b0);
		add_req(KIND_RET_IMM14, SET_A64, 32'h0004_0000, 64'h8000, 64'h0, 64'h0,
			16'h8000, 32'h0, 1'b0);
		add_req(KIND_RET_IMM14, SET_T16, 32'hffff_ffff, 64'h8000, 64'h0, 64'h5000,
			16'h0040, 32'h0, 1'b0);
		add_req(kind_t'(5'd31), SET_A64, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff,
			64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 16'hffff, 32'hffff_ffff,
			1'b0);

		for (int unsigned i = 0; i < RandomItems; i++)
			add_random_req(i == 0 || i == DrainAt);
		quiet_from = request_q.size() - QuietTail;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (request_q.size() > 0 || s_tvalid || pending_results.size() > 0)
			@(posedge clk);
		repeat (TailCycles) @(posedge clk);

		$display("tb: %0d slot requests over all kinds and instruction sets sent,", n_in);
		$display("tb: %0d results checked under idle bursts, hold-off and drains", n_out);
		if (fail_count == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
